// ===== hw/rtl/dqs_delay_window_training_unit_macros.svh =====
// Assertion macros shared by the DQS delay window training RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef DQS_DELAY_WINDOW_TRAINING_UNIT_MACROS_SVH
`define DQS_DELAY_WINDOW_TRAINING_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DWT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dwt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define DWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dwt assertion failed");

`endif

// ===== hw/rtl/dqs_dwt_pkg.sv =====
// Package for the DQS delay window training unit: codes, patterns, result type.
// No dependencies.
package dqs_dwt_pkg;

    localparam logic [31:0] PAT_EDGE  = {16'hffff, 16'h0};
    localparam logic [31:0] PAT_CHECK = {16'h5a5a, 16'ha5a5};

    localparam logic [1:0] PH_READ   = 2'd0;
    localparam logic [1:0] PH_WRITE  = 2'd1;
    localparam logic [1:0] PH_VERIFY = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

    localparam logic [1:0] IDX_LAST = 2'd3;

    localparam logic CFG_DELAY_STEP = 1'b0;
    localparam logic CFG_SCAN_LIMIT = 1'b1;

    localparam logic [7:0] DELAY_STEP_RST = 8'd2;
    localparam logic [7:0] SCAN_LIMIT_RST = 8'h80;

    typedef struct packed {
        logic [31:0] delay_word;
        logic        pattern_swap;
        logic [1:0]  phase;
        logic [7:0]  read_delay_final;
        logic [7:0]  write_delay_final;
        logic        verify_failed;
        logic        done_res;
    } t_result;

    // Expected read-back word for a position; the order flips with the toggle.
    function automatic logic [31:0] expected_word(input logic toggle, input logic [1:0] idx);
        logic upper_half;
        upper_half = idx[1];
        if (toggle) begin
            expected_word = upper_half ? PAT_CHECK : PAT_EDGE;
        end else begin
            expected_word = upper_half ? PAT_EDGE : PAT_CHECK;
        end
    endfunction

    // Window midpoint, sum kept in 9 bits.
    function automatic logic [7:0] midpoint(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        midpoint = sum[8:1];
    endfunction

endpackage

// ===== hw/rtl/dqs_dwt_in_if.sv =====
// Input channel of the DQS delay window training unit: start and read-back items.
// No dependencies.
interface dqs_dwt_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] register_word;
    logic [31:0] read_data;
    logic [1:0]  word_index;

    modport source (output valid, kind, register_word, read_data, word_index, input ready);
    modport sink   (input valid, kind, register_word, read_data, word_index, output ready);
endinterface

// ===== hw/rtl/dqs_dwt_out_if.sv =====
// Result channel of the DQS delay window training unit.
// No dependencies.
interface dqs_dwt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] delay_word;
    logic        pattern_swap;
    logic [1:0]  phase;
    logic [7:0]  read_delay_final;
    logic [7:0]  write_delay_final;
    logic        verify_failed;
    logic        done_res;

    modport source (output valid, delay_word, pattern_swap, phase, read_delay_final,
                    write_delay_final, verify_failed, done_res, input ready);
    modport sink   (input valid, delay_word, pattern_swap, phase, read_delay_final,
                    write_delay_final, verify_failed, done_res, output ready);
endinterface

// ===== hw/rtl/dqs_delay_window_training_unit.sv =====
// Path: an input transfer is captured in the input register, then its result is loaded into the result register.
// Throughput: one item per cycle while the result register is free or being drained; a stalled sink holds the input.
// Items that close no trial (words 0..2, words after done) give no result.
// Reset (i_rst_n low, synchronous): phase read scan, all delays, edges and flags cleared,
// delay_step 2, scan_limit 128; both pipeline registers emptied.
// Depends on dqs_dwt_pkg, dqs_dwt_in_if, dqs_dwt_out_if and the macros header.
`include "dqs_delay_window_training_unit_macros.svh"

module dqs_delay_window_training_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    dqs_dwt_in_if.sink        i_in,
    dqs_dwt_out_if.source     o_out
);

    // Configuration registers
    logic [7:0] r_step;
    logic [7:0] r_limit;

    // Input register
    logic        r_in_valid;
    logic        r_in_kind;
    logic [31:0] r_in_reg;
    logic [31:0] r_in_data;
    logic [1:0]  r_in_idx;

    // Training state
    logic [1:0]  r_phase,   n_phase;
    logic        r_toggle,  n_toggle;
    logic        r_found,   n_found;
    logic [7:0]  r_trial,   n_trial;
    logic [7:0]  r_low,     n_low;
    logic [7:0]  r_wdo,     n_wdo;
    logic [15:0] r_other,   n_other;
    logic [7:0]  r_rdc,     n_rdc;
    logic [7:0]  r_wdc,     n_wdc;
    logic        r_mismatch, n_mismatch;

    // Result register
    logic               r_out_valid;
    dqs_dwt_pkg::t_result r_out;

    logic               advance;
    logic               apply;
    logic               c_emit;
    logic               c_done;
    logic [7:0]         c_wr;
    logic [7:0]         c_rd;
    logic               mis_next;
    logic [7:0]         c_upper;
    logic [7:0]         c_mid;
    logic               c_close;
    dqs_dwt_pkg::t_result c_res;

    // The input register moves on whenever the result register is free or being drained.
    assign advance    = !r_out_valid || o_out.ready;
    assign apply      = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // Configuration writes: taken whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= dqs_dwt_pkg::DELAY_STEP_RST;
            r_limit <= dqs_dwt_pkg::SCAN_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dqs_dwt_pkg::CFG_DELAY_STEP: r_step  <= i_cfg_data;
                dqs_dwt_pkg::CFG_SCAN_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_kind <= i_in.kind;
            r_in_reg  <= i_in.register_word;
            r_in_data <= i_in.read_data;
            r_in_idx  <= i_in.word_index;
        end
    end

    // Shared arithmetic: upper edge is current trial minus step, wrapping at 8 bits.
    assign mis_next = r_mismatch
                    | (r_in_data != dqs_dwt_pkg::expected_word(r_toggle, r_in_idx));
    assign c_upper  = r_trial - r_step;
    assign c_mid    = dqs_dwt_pkg::midpoint(c_upper, r_low);
    assign c_close  = mis_next || (r_trial > r_limit);

    // One item: update the training state and build the result, if any.
    always_comb begin
        n_phase    = r_phase;
        n_toggle   = r_toggle;
        n_found    = r_found;
        n_trial    = r_trial;
        n_low      = r_low;
        n_wdo      = r_wdo;
        n_other    = r_other;
        n_rdc      = r_rdc;
        n_wdc      = r_wdc;
        n_mismatch = r_mismatch;
        c_emit     = 1'b0;
        c_done     = 1'b0;
        c_wr       = r_wdo;
        c_rd       = r_rdc;

        if (apply) begin
            if (r_in_kind == dqs_dwt_pkg::KIND_START) begin
                // Restart from any phase with the captured register word.
                n_wdo      = r_in_reg[15:8];
                n_other    = r_in_reg[31:16];
                n_phase    = dqs_dwt_pkg::PH_READ;
                n_toggle   = 1'b0;
                n_found    = 1'b0;
                n_trial    = 8'd0;
                n_low      = 8'd0;
                n_rdc      = 8'd0;
                n_wdc      = 8'd0;
                n_mismatch = 1'b0;
                c_emit     = 1'b1;
                c_wr       = r_in_reg[15:8];
                c_rd       = 8'd0;
            end else if (r_phase != dqs_dwt_pkg::PH_DONE) begin
                n_mismatch = mis_next;
                if (r_in_idx == dqs_dwt_pkg::IDX_LAST) begin
                    c_emit = 1'b1;
                    case (r_phase)
                        dqs_dwt_pkg::PH_READ: begin
                            n_toggle   = ~r_toggle;
                            n_mismatch = 1'b0;
                            if (r_found && c_close) begin
                                // Upper edge reached: fix the read delay, start the write scan.
                                n_rdc   = c_mid;
                                n_phase = dqs_dwt_pkg::PH_WRITE;
                                n_found = 1'b0;
                                n_trial = r_wdo;
                                c_wr    = r_wdo;
                                c_rd    = c_mid;
                            end else begin
                                if (!r_found && !mis_next) begin
                                    n_low   = r_trial;
                                    n_found = 1'b1;
                                end
                                n_trial = r_trial + r_step;
                                c_wr    = r_wdo;
                                c_rd    = r_trial + r_step;
                            end
                        end
                        dqs_dwt_pkg::PH_WRITE: begin
                            n_mismatch = 1'b0;
                            if (!r_found) begin
                                // Downward scan, saturating at 0.
                                n_toggle = ~r_toggle;
                                if (mis_next || (r_trial == 8'd0)) begin
                                    n_low   = r_trial;
                                    n_found = 1'b1;
                                    n_trial = r_wdo;
                                end else if (r_trial <= r_step) begin
                                    n_trial = 8'd0;
                                end else begin
                                    n_trial = r_trial - r_step;
                                end
                                c_wr = n_trial;
                            end else if (c_close) begin
                                // Hold the pattern order for the verify trial.
                                n_wdc   = c_mid;
                                n_phase = dqs_dwt_pkg::PH_VERIFY;
                                c_wr    = c_mid;
                            end else begin
                                n_toggle = ~r_toggle;
                                n_trial  = r_trial + r_step;
                                c_wr     = r_trial + r_step;
                            end
                            c_rd = r_rdc;
                        end
                        dqs_dwt_pkg::PH_VERIFY: begin
                            n_phase = dqs_dwt_pkg::PH_DONE;
                            c_done  = 1'b1;
                            c_wr    = r_wdc;
                            c_rd    = r_rdc;
                        end
                        default: begin
                            c_emit = 1'b0;
                        end
                    endcase
                end
            end
        end

        c_res.delay_word        = {n_other, c_wr, c_rd};
        c_res.pattern_swap      = n_toggle;
        c_res.phase             = n_phase;
        c_res.read_delay_final  = n_rdc;
        c_res.write_delay_final = n_wdc;
        c_res.verify_failed     = c_done && n_mismatch;
        c_res.done_res          = c_done;
    end

    // Training state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= dqs_dwt_pkg::PH_READ;
            r_toggle   <= 1'b0;
            r_found    <= 1'b0;
            r_trial    <= 8'd0;
            r_low      <= 8'd0;
            r_wdo      <= 8'd0;
            r_other    <= 16'd0;
            r_rdc      <= 8'd0;
            r_wdc      <= 8'd0;
            r_mismatch <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_toggle   <= n_toggle;
            r_found    <= n_found;
            r_trial    <= n_trial;
            r_low      <= n_low;
            r_wdo      <= n_wdo;
            r_other    <= n_other;
            r_rdc      <= n_rdc;
            r_wdc      <= n_wdc;
            r_mismatch <= n_mismatch;
        end
    end

    // Result register: load on advance, hold while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= apply && c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && c_emit) begin
            r_out <= c_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.delay_word        = r_out.delay_word;
    assign o_out.pattern_swap      = r_out.pattern_swap;
    assign o_out.phase             = r_out.phase;
    assign o_out.read_delay_final  = r_out.read_delay_final;
    assign o_out.write_delay_final = r_out.write_delay_final;
    assign o_out.verify_failed     = r_out.verify_failed;
    assign o_out.done_res          = r_out.done_res;

    // Assertions
    `DWT_ASSERT_NOW(a_done_phase, i_clk, i_rst_n,
        r_out_valid && r_out.done_res, r_out.phase == dqs_dwt_pkg::PH_DONE)
    `DWT_ASSERT_NOW(a_fail_only_done, i_clk, i_rst_n,
        r_out_valid && r_out.verify_failed, r_out.done_res)
    `DWT_ASSERT_NOW(a_read_scan_no_choice, i_clk, i_rst_n,
        r_out_valid && (r_out.phase == dqs_dwt_pkg::PH_READ), r_out.read_delay_final == 8'd0)
    `DWT_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n,
        (r_phase == dqs_dwt_pkg::PH_DONE)
            && !(r_in_valid && (r_in_kind == dqs_dwt_pkg::KIND_START)),
        r_phase == dqs_dwt_pkg::PH_DONE)

endmodule
